@@ sv/cns_pkg.sv @@
// ----------------------------------------------------------------------------
// cns_pkg
// Shared types, widths and helpers for the correlated noise sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cns_pkg;

    localparam int FRAC_BITS = 16;
    localparam int RAND_FRAC = 15;
    localparam int MEAN_W    = 32;
    localparam int COV_W     = 31;
    localparam int RAND_W    = 16;
    localparam int Q_W       = 32;
    localparam int ROOT_W    = (COV_W + FRAC_BITS + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int DREM_W    = ROOT_W + 1;
    localparam int CMP_W     = Q_W + ROOT_W + FRAC_BITS;
    localparam int P0_W      = ROOT_W + 1 + RAND_W;
    localparam int P1_W      = Q_W + 1 + RAND_W;
    localparam int SUM_W     = P1_W + 2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIAG_ZERO = 2'd1;
    localparam logic [1:0] ST_RAD_NEG   = 2'd2;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_x;
        logic signed [MEAN_W-1:0] mean_y;
        logic        [COV_W-1:0]  cov_00;
        logic signed [MEAN_W-1:0] cov_10;
        logic        [COV_W-1:0]  cov_11;
        logic signed [RAND_W-1:0] rand_a;
        logic signed [RAND_W-1:0] rand_b;
    } cns_in_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] sample_x;
        logic signed [MEAN_W-1:0] sample_y;
        logic        [1:0]        status;
    } cns_out_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_x;
        logic signed [MEAN_W-1:0] mean_y;
        logic        [Q_W-1:0]    mag;
        logic                     neg;
        logic        [COV_W-1:0]  c11;
        logic signed [RAND_W-1:0] rand_a;
        logic signed [RAND_W-1:0] rand_b;
        logic        [ROOT_W-1:0] s00;
        logic        [Q_W-1:0]    q;
        logic        [1:0]        status;
    } cns_side_t;

    function automatic logic signed [MEAN_W-1:0] sat_mean(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7FFF_FFFF);
        lo = -SUM_W'(32'sh7FFF_FFFF) - SUM_W'(1);
        if (v > hi) begin
            return hi[MEAN_W-1:0];
        end else if (v < lo) begin
            return lo[MEAN_W-1:0];
        end
        return v[MEAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/cns_sqrt.sv @@
// ----------------------------------------------------------------------------
// cns_sqrt
// Pipelined integer square root, one root bit per stage, side data alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module cns_sqrt (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [cns_pkg::RAD_W-1:0] in_rad,
    input  wire cns_pkg::cns_side_t        in_side,
    output logic                           out_valid,
    output logic [cns_pkg::ROOT_W-1:0]     out_root,
    output cns_pkg::cns_side_t             out_side
);
    import cns_pkg::*;

    logic              valid_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    cns_side_t         side_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        cns_side_t         side_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial  = REM_W'({root_in, 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

@@ sv/cns_div.sv @@
// ----------------------------------------------------------------------------
// cns_div
// Pipelined restoring divider: (mag << FRAC_BITS) / s00, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cns_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire cns_pkg::cns_side_t in_side,
    output logic                    out_valid,
    output cns_pkg::cns_side_t      out_side
);
    import cns_pkg::*;

    logic              valid_reg [Q_W];
    logic [DREM_W-1:0] rem_reg   [Q_W];
    logic [Q_W-1:0]    bits_reg  [Q_W];
    cns_side_t         side_reg  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic              v_in;
        logic [DREM_W-1:0] rem_in;
        logic [Q_W-1:0]    bits_in;
        cns_side_t         side_in;
        logic [DREM_W-1:0] t;
        logic [DREM_W-1:0] d;
        logic [DREM_W-1:0] rem_next;
        logic [Q_W-1:0]    bits_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = DREM_W'(in_side.mag[Q_W-1 -: FRAC_BITS]);
            assign bits_in = {in_side.mag[Q_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign bits_in = bits_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            t = {rem_in[DREM_W-2:0], bits_in[Q_W-1]};
            d = DREM_W'(side_in.s00);
            if (t >= d) begin
                rem_next  = t - d;
                bits_next = {bits_in[Q_W-2:0], 1'b1};
            end else begin
                rem_next  = t;
                bits_next = {bits_in[Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                bits_reg[k] <= bits_next;
                side_reg[k] <= side_in;
            end
        end
    end

    always_comb begin
        out_side   = side_reg[Q_W-1];
        out_side.q = bits_reg[Q_W-1];
    end
    assign out_valid = valid_reg[Q_W-1];

endmodule

`default_nettype wire

@@ sv/cns_out.sv @@
// ----------------------------------------------------------------------------
// cns_out
// Product, sum and saturation stages that turn the factor into a sample.
// ----------------------------------------------------------------------------
`default_nettype none

module cns_out (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire cns_pkg::cns_side_t         in_side,
    input  wire logic [cns_pkg::ROOT_W-1:0] in_s11,
    output logic                            out_valid,
    output cns_pkg::cns_out_t               out_data
);
    import cns_pkg::*;

    logic                     mul_valid_reg;
    cns_side_t                mul_side_reg;
    logic signed [P0_W-1:0]   p0_reg;
    logic signed [P1_W-1:0]   p1_reg;
    logic signed [P0_W-1:0]   p2_reg;
    logic signed [Q_W:0]      s10;

    logic                     add_valid_reg;
    cns_side_t                add_side_reg;
    logic signed [SUM_W-1:0]  sx_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [P0_W-1:0]   dx;

    logic                     fin_valid_reg;
    cns_out_t                 fin_reg;
    cns_out_t                 fin_next;
    logic signed [SUM_W-1:0]  dy;
    logic signed [SUM_W-1:0]  sy;

    assign s10 = in_side.neg ? -$signed({1'b0, in_side.q}) : $signed({1'b0, in_side.q});
    assign dx  = p0_reg >>> RAND_FRAC;

    always_comb begin
        dy = sum_reg >>> RAND_FRAC;
        sy = SUM_W'(add_side_reg.mean_y) + dy;
        if (add_side_reg.status == ST_OK) begin
            fin_next.sample_x = sat_mean(sx_reg);
            fin_next.sample_y = sat_mean(sy);
        end else begin
            fin_next.sample_x = add_side_reg.mean_x;
            fin_next.sample_y = add_side_reg.mean_y;
        end
        fin_next.status = add_side_reg.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= in_valid;
            add_valid_reg <= mul_valid_reg;
            fin_valid_reg <= add_valid_reg;
        end
        if (en) begin
            mul_side_reg <= in_side;
            p0_reg       <= $signed({1'b0, in_side.s00}) * in_side.rand_a;
            p1_reg       <= s10 * in_side.rand_a;
            p2_reg       <= $signed({1'b0, in_s11}) * in_side.rand_b;
            add_side_reg <= mul_side_reg;
            sx_reg       <= SUM_W'(mul_side_reg.mean_x) + SUM_W'(dx);
            sum_reg      <= SUM_W'(p1_reg) + SUM_W'(p2_reg);
            fin_reg      <= fin_next;
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_data  = fin_reg;

endmodule

`default_nettype wire

@@ sv/correlated_noise_sampler_2d.sv @@
// ----------------------------------------------------------------------------
// correlated_noise_sampler_2d
// Draws one correlated 2-D sample per beat through a 2x2 Cholesky factor.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the skid is empty and returns one result beat
// per input beat, in order. The path is two 24-stage square-root pipelines,
// a 32-stage divider, a squaring stage, two check stages, three product/sum
// stages and the output register. A one-beat skid behind the output register
// lets the pipeline advance one more beat while a result waits; once the skid
// is full the input closes.
`default_nettype none

module correlated_noise_sampler_2d (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cns_pkg::cns_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output cns_pkg::cns_out_t     m_data
);
    import cns_pkg::*;

    logic              en;
    cns_side_t         side0;
    logic [RAD_W-1:0]  rad0;

    logic              sq1_valid;
    logic [ROOT_W-1:0] sq1_root;
    cns_side_t         sq1_side;

    logic              chk_valid_reg;
    cns_side_t         chk_side_reg;
    cns_side_t         chk_side_next;

    logic              div_valid;
    cns_side_t         div_side;

    logic              mul_valid_reg;
    cns_side_t         mul_side_reg;
    logic [2*Q_W-1:0]  sq_reg;

    logic              rad_valid_reg;
    cns_side_t         rad_side_reg;
    cns_side_t         rad_side_next;
    logic [RAD_W-1:0]  rad_reg;
    logic [COV_W-1:0]  diff;

    logic              sq2_valid;
    logic [ROOT_W-1:0] sq2_root;
    cns_side_t         sq2_side;

    logic              p_valid;
    cns_out_t          p_data;

    logic              m_valid_reg;
    logic              m_valid_next;
    cns_out_t          m_data_reg;
    cns_out_t          m_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    cns_out_t          skid_data_reg;
    cns_out_t          skid_data_next;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_comb begin
        side0.mean_x = s_data.mean_x;
        side0.mean_y = s_data.mean_y;
        side0.mag    = s_data.cov_10[MEAN_W-1] ? Q_W'(-s_data.cov_10) : Q_W'(s_data.cov_10);
        side0.neg    = s_data.cov_10[MEAN_W-1];
        side0.c11    = s_data.cov_11;
        side0.rand_a = s_data.rand_a;
        side0.rand_b = s_data.rand_b;
        side0.s00    = '0;
        side0.q      = '0;
        side0.status = (s_data.cov_00 == '0) ? ST_DIAG_ZERO : ST_OK;
        rad0         = RAD_W'({s_data.cov_00, {FRAC_BITS{1'b0}}});
    end

    cns_sqrt u_sqrt_diag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_rad    (rad0),
        .in_side   (side0),
        .out_valid (sq1_valid),
        .out_root  (sq1_root),
        .out_side  (sq1_side)
    );

    always_comb begin
        chk_side_next     = sq1_side;
        chk_side_next.s00 = sq1_root;
        if (sq1_side.status == ST_OK
                && CMP_W'(sq1_side.mag) >= (CMP_W'(sq1_root) << FRAC_BITS)) begin
            chk_side_next.status = ST_RAD_NEG;
        end
    end

    cns_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chk_valid_reg),
        .in_side   (chk_side_reg),
        .out_valid (div_valid),
        .out_side  (div_side)
    );

    always_comb begin
        diff          = mul_side_reg.c11 - sq_reg[COV_W+FRAC_BITS-1:FRAC_BITS];
        rad_side_next = mul_side_reg;
        if (mul_side_reg.status == ST_OK
                && (sq_reg >> FRAC_BITS) > (2*Q_W)'(mul_side_reg.c11)) begin
            rad_side_next.status = ST_RAD_NEG;
        end
    end

    cns_sqrt u_sqrt_rad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rad_valid_reg),
        .in_rad    (rad_reg),
        .in_side   (rad_side_reg),
        .out_valid (sq2_valid),
        .out_root  (sq2_root),
        .out_side  (sq2_side)
    );

    cns_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq2_valid),
        .in_side   (sq2_side),
        .in_s11    (sq2_root),
        .out_valid (p_valid),
        .out_data  (p_data)
    );

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = p_valid;
                m_data_next  = p_data;
            end
        end else if (p_valid && en) begin
            skid_valid_next = 1'b1;
            skid_data_next  = p_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg  <= 1'b0;
            mul_valid_reg  <= 1'b0;
            rad_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                chk_valid_reg <= sq1_valid;
                mul_valid_reg <= div_valid;
                rad_valid_reg <= mul_valid_reg;
            end
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        if (en) begin
            chk_side_reg <= chk_side_next;
            mul_side_reg <= div_side;
            sq_reg       <= div_side.q * div_side.q;
            rad_side_reg <= rad_side_next;
            rad_reg      <= RAD_W'({diff, {FRAC_BITS{1'b0}}});
        end
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled without a stalled output");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_ready |=> m_valid_reg && !skid_valid_reg)
        else $error("skid beat not moved to output");

endmodule

`default_nettype wire
